>>> hw/rtl/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants for the fixed partition fit allocator: operation
// and fit mode codes, configuration register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    // Fixed field widths of the command and result words.
    localparam int OP_W       = 2;
    localparam int PIDX_W     = 4;
    localparam int SIZE_IN_W  = 16;
    localparam int PID_W      = 16;
    localparam int GIDX_W     = 4;
    localparam int TOTAL_W    = 20;
    localparam int INUSE_W    = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Saturation ceiling of the fragmentation total.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

    // Reset value of the in-use count configuration register.
    localparam logic [INUSE_W-1:0] INUSE_RESET = 5'd16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // Fit modes; any other code behaves as first fit.
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INUSE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } fpfa_state_t;

endpackage

>>> hw/rtl/fixed_partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition table with first, best and worst fit placement. Sizes and
// per-partition allocation records live in two synchronous memories; the
// allocated marks sit in flip-flops so that a flush clears them at once.
// ----------------------------------------------------------------------------
//  Channel   Ports                                                  Handshake
//  command   operation, partition_index, size_value, process_id     start & !busy
//  result    granted, granted_index, process_id_echo,               done, one cycle
//            fragmentation_total
//  config    cfg_we, cfg_index, cfg_data                            cfg_we
//
//  A word is answered once the active partitions have been scanned; when none
//  is active the scan is skipped. Each memory has a single read port, so the
//  scan reads one entry per cycle, then ST_DRAIN empties the read pipeline and
//  ST_WRITE writes back. busy drops in the done cycle, so the next word can be
//  taken then; none is taken while a word is in progress. Reset clears the
//  marks and the total and restores the configuration defaults; memory contents
//  are undefined until loaded. The result receiver cannot stall the block.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator
    import fpfa_pkg::*;
#(
    parameter int MAX_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Command word
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       operation,
    input  logic [PIDX_W-1:0]     partition_index,
    input  logic [SIZE_IN_W-1:0]  size_value,
    input  logic [PID_W-1:0]      process_id,
    // Result word
    output logic                  done,
    output logic                  granted,
    output logic [GIDX_W-1:0]     granted_index,
    output logic [PID_W-1:0]      process_id_echo,
    output logic [TOTAL_W-1:0]    fragmentation_total
);

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int SUM_W = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;
    localparam int REC_W = PID_W + SIZE_BITS;

    // Sequencer and configuration registers.
    fpfa_state_t state_reg, state_next;
    logic [INUSE_W-1:0] inuse_reg;
    logic [MODE_W-1:0]  mode_reg;

    // Latched command word.
    logic [OP_W-1:0]      op_reg, op_next;
    logic [PIDX_W-1:0]    idx_reg, idx_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;
    logic [PID_W-1:0]     pid_reg, pid_next;

    // Scan control and search state.
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [TOTAL_W-1:0]   acc_reg, acc_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] gap_reg, gap_next;
    logic [MAX_PARTITIONS-1:0] mark_reg, mark_next;

    // Result registers.
    logic                 done_reg, done_next;
    logic                 granted_reg, granted_next;
    logic [GIDX_W-1:0]    gidx_reg, gidx_next;
    logic [PID_W-1:0]     pid_echo_reg, pid_echo_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;

    // Memories and their registered read data.
    logic [SIZE_BITS-1:0] size_mem [MAX_PARTITIONS];
    logic [REC_W-1:0]     rec_mem  [MAX_PARTITIONS];
    logic [SIZE_BITS-1:0] size_rd_reg;
    logic [REC_W-1:0]     rec_rd_reg;

    // FSM outputs.
    logic scan_issue;
    logic commit;

    // Combinational helpers.
    logic [CNT_W-1:0]     active_count;
    logic                 last_addr;
    logic                 load_ok;
    logic                 size_we;
    logic                 rec_we;
    logic [SIZE_BITS-1:0] rd_leftover;
    logic                 rd_marked;
    logic                 rd_fits;
    logic [SIZE_BITS-1:0] rd_gap;
    logic                 take_entry;
    logic [SUM_W-1:0]     scan_sum;
    logic [TOTAL_W-1:0]   scan_sum_sat;
    logic [SUM_W-1:0]     grant_sum;
    logic [TOTAL_W-1:0]   grant_sum_sat;

    // Number of partitions that take part in the scan.
    always_comb
    begin
        if (32'(inuse_reg) > MAX_PARTITIONS)
        begin
            active_count = CNT_W'(MAX_PARTITIONS);
        end
        else
        begin
            active_count = CNT_W'(inuse_reg);
        end
    end

    assign last_addr = (CNT_W'(addr_reg) == (count_reg - CNT_W'(1)));
    assign load_ok   = (32'(idx_reg) < MAX_PARTITIONS);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (active_count == '0) ? ST_WRITE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        busy       = 1'b1;
        scan_issue = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_SCAN:
            begin
                scan_issue = 1'b1;
            end
            ST_DRAIN:
            begin
                busy = 1'b1;
            end
            ST_WRITE:
            begin
                commit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Evaluation of the entry whose read data has just arrived.
    assign rd_leftover = rec_rd_reg[SIZE_BITS-1:0];
    assign rd_marked   = mark_reg[rd_idx_reg];
    assign rd_fits     = !rd_marked && (size_rd_reg >= req_reg);
    assign rd_gap      = size_rd_reg - req_reg;

    always_comb
    begin
        take_entry = 1'b0;
        if (rd_fits)
        begin
            if (!found_reg)
            begin
                take_entry = 1'b1;
            end
            else if ((mode_reg == MODE_BEST) && (rd_gap < gap_reg))
            begin
                take_entry = 1'b1;
            end
            else if ((mode_reg == MODE_WORST) && (rd_gap > gap_reg))
            begin
                take_entry = 1'b1;
            end
        end
    end

    // Saturating adds for the running total and the final grant.
    assign scan_sum      = SUM_W'(acc_reg) + SUM_W'(rd_leftover);
    assign scan_sum_sat  = (scan_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : TOTAL_W'(scan_sum);
    assign grant_sum     = SUM_W'(acc_reg) + SUM_W'(gap_reg);
    assign grant_sum_sat = (grant_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                           : TOTAL_W'(grant_sum);

    // Memory write enables, used only in the write-back cycle.
    assign size_we = commit && (op_reg == OP_LOAD) && load_ok;
    assign rec_we  = commit && (op_reg == OP_ALLOC) && found_reg;

    // Datapath next values.
    always_comb
    begin
        op_next       = op_reg;
        idx_next      = idx_reg;
        req_next      = req_reg;
        pid_next      = pid_reg;
        count_next    = count_reg;
        addr_next     = addr_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        acc_next      = acc_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        gap_next      = gap_reg;
        mark_next     = mark_reg;
        done_next     = 1'b0;
        granted_next  = granted_reg;
        gidx_next     = gidx_reg;
        pid_echo_next = pid_echo_reg;
        total_next    = total_reg;

        // Latch the command word and clear the search state.
        if (!busy && start)
        begin
            op_next    = operation;
            idx_next   = partition_index;
            req_next   = SIZE_BITS'(size_value);
            pid_next   = process_id;
            count_next = active_count;
            addr_next  = '0;
            acc_next   = '0;
            found_next = 1'b0;
            pick_next  = '0;
            gap_next   = '0;
        end

        // Issue one memory read per cycle.
        if (scan_issue)
        begin
            rd_valid_next = 1'b1;
            rd_idx_next   = addr_reg;
            addr_next     = addr_reg + IDX_W'(1);
        end

        // Accumulate leftovers of allocated entries and track the best pick.
        if (rd_valid_reg)
        begin
            if (rd_marked)
            begin
                acc_next = scan_sum_sat;
            end
            if (take_entry)
            begin
                found_next = 1'b1;
                pick_next  = rd_idx_reg;
                gap_next   = rd_gap;
            end
        end

        // Write back marks and form the result word.
        if (commit)
        begin
            done_next     = 1'b1;
            granted_next  = 1'b0;
            gidx_next     = '0;
            pid_echo_next = pid_reg;
            total_next    = acc_reg;
            if ((op_reg == OP_ALLOC) && found_reg)
            begin
                mark_next[pick_reg] = 1'b1;
                granted_next        = 1'b1;
                gidx_next           = GIDX_W'(pick_reg);
                total_next          = grant_sum_sat;
            end
            else if (op_reg == OP_FLUSH)
            begin
                mark_next  = '0;
                total_next = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            inuse_reg    <= INUSE_RESET;
            mode_reg     <= MODE_FIRST;
            rd_valid_reg <= 1'b0;
            mark_reg     <= '0;
            done_reg     <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            mark_reg     <= mark_next;
            done_reg     <= done_next;
            total_reg    <= total_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INUSE: inuse_reg <= cfg_data;
                    CFG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                    default:   inuse_reg <= inuse_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        req_reg      <= req_next;
        pid_reg      <= pid_next;
        count_reg    <= count_next;
        addr_reg     <= addr_next;
        rd_idx_reg   <= rd_idx_next;
        acc_reg      <= acc_next;
        found_reg    <= found_next;
        pick_reg     <= pick_next;
        gap_reg      <= gap_next;
        granted_reg  <= granted_next;
        gidx_reg     <= gidx_next;
        pid_echo_reg <= pid_echo_next;
    end

    // Partition size memory: written by loads, read during the scan.
    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[IDX_W'(idx_reg)] <= req_reg;
        end
        size_rd_reg <= size_mem[addr_reg];
    end

    // Allocation record memory: owner id and leftover recorded at grant time.
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[pick_reg] <= {pid_reg, gap_reg};
        end
        rec_rd_reg <= rec_mem[addr_reg];
    end

    assign done                = done_reg;
    assign granted             = granted_reg;
    assign granted_index       = gidx_reg;
    assign process_id_echo     = pid_echo_reg;
    assign fragmentation_total = total_reg;

endmodule
